/* sv/cti_pkg.sv */
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants for the calibration table interpolator.
// ----------------------------------------------------------------------------
package cti_pkg;

    // default table depth
    localparam int MAX_ROWS_DEF = 64;

    // item command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // input item
    typedef struct packed {
        logic        cmd;
        logic [5:0]  row_index;
        logic [15:0] row_x;
        logic [15:0] row_y;
        logic [15:0] power_mw;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [15:0] corrected_mw;
        logic        passed_through;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LAST,
        S_CHK_LAST,
        S_SCAN,
        S_MUL,
        S_DIV_GO,
        S_DIV
    } t_state;

    // result source
    typedef enum logic [1:0] {
        SEL_PASS,
        SEL_MATCH,
        SEL_INTERP
    } t_sel;

    // controller to datapath commands
    typedef struct packed {
        logic wr;         // write a table row from the item
        logic load;       // latch power, point read address at last row
        logic addr_zero;  // point read address at row 0
        logic scan_init;  // row 0 in flight, start the scan counters
        logic step;       // advance to the next row
        logic seg;        // segment found, latch differences
        logic mul;        // form the product
        logic div_start;  // launch the divider
        logic emit;       // register a result
        t_sel sel;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic n_lt2;
        logic gt_row;
        logic lt_row;
        logic eq_row;
        logic seg_hit;
        logic first;
        logic at_last;
        logic div_done;
    } t_ctl_sts;

endpackage

/* sv/calibration_table_interpolator.sv */
// ----------------------------------------------------------------------------
// calibration_table_interpolator
// Row write item: busy never rises, no result.
// Lookup item: gives one result; the row
// scan reads one table row per cycle, then the restoring divider finishes an
// interpolated value. One lookup at a time; the result strobe cannot stall.
// Reset clears rows_in_use and the sequencer; table rows hold nothing
// defined until written.
// ----------------------------------------------------------------------------
module calibration_table_interpolator #(
    parameter int MAX_ROWS = cti_pkg::MAX_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cti_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    output logic               o_done,
    output cti_pkg::t_out_item o_result
);

    cti_pkg::t_ctl_cmd ctl_cmd;
    cti_pkg::t_ctl_sts ctl_sts;

    // sequencer
    cti_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd_bit (i_item.cmd),
        .i_sts     (ctl_sts),
        .o_cmd     (ctl_cmd),
        .busy      (busy)
    );

    // table and arithmetic
    cti_dpath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

/* sv/cti_div.sv */
// ----------------------------------------------------------------------------
// cti_div
// Restoring divider, one quotient bit per cycle. The dividend's upper half
// must be below the divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module cti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic [15:0] r_rem;
    logic [15:0] r_lo;
    logic [15:0] r_quo;
    logic [15:0] r_dsr;
    logic [4:0]  r_cnt;
    logic        r_done;

    logic [16:0] trial;
    logic        q_bit;
    logic [15:0] n_rem;

    // one subtract and compare per step
    always_comb begin
        trial = {r_rem, r_lo[15]};
        q_bit = (trial >= {1'b0, r_dsr});
        if (q_bit) begin
            n_rem = 16'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[15:0];
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 5'd16;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[31:16];
            r_lo  <= i_dividend[15:0];
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[14:0], 1'b0};
            r_quo <= {r_quo[14:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/cti_dpath.sv */
// ----------------------------------------------------------------------------
// cti_dpath
// Table memory, row scan registers, interpolation arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module cti_dpath #(
    parameter int MAX_ROWS = cti_pkg::MAX_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata,
    input  cti_pkg::t_in_item   i_item,
    input  cti_pkg::t_ctl_cmd   i_cmd,
    output cti_pkg::t_ctl_sts   o_sts,
    output logic                o_done,
    output cti_pkg::t_out_item  o_result
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    logic [31:0] mem [MAX_ROWS];

    logic [6:0]         r_rows;
    logic [15:0]        r_p;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_cur;
    logic [31:0]        r_rd;
    logic [15:0]        r_prev_x;
    logic [15:0]        r_prev_y;
    logic [15:0]        r_dx;
    logic [15:0]        r_den;
    logic signed [16:0] r_dy;
    logic signed [33:0] r_prod;
    logic               r_out_vld;
    cti_pkg::t_out_item r_out;

    logic [CW-1:0] n_sat;
    logic [AW-1:0] last;
    logic [AW-1:0] wr_addr;
    logic          wr_ok;
    logic [15:0]   rd_x;
    logic [15:0]   rd_y;
    logic [31:0]   mag;
    logic          div_done;
    logic [15:0]   quo;

    // rows in use, saturated to the table depth
    always_comb begin
        if (32'(r_rows) > MAX_ROWS) begin
            n_sat = CW'(MAX_ROWS);
        end else begin
            n_sat = CW'(r_rows);
        end
        last    = AW'(n_sat - CW'(1));
        wr_addr = AW'(i_item.row_index);
        wr_ok   = (32'(i_item.row_index) < MAX_ROWS);
        rd_x    = r_rd[31:16];
        rd_y    = r_rd[15:0];
        mag     = r_prod[33] ? 32'(-r_prod) : 32'(r_prod);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_wdata;
        end
    end

    // table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            mem[wr_addr] <= {i_item.row_x, i_item.row_y};
        end
        r_rd <= mem[r_addr];
    end

    // scan address and row counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p    <= i_item.power_mw;
            r_addr <= last;
        end else if (i_cmd.addr_zero) begin
            r_addr <= '0;
        end else if (i_cmd.scan_init) begin
            r_addr <= AW'(1);
            r_cur  <= '0;
        end else if (i_cmd.step) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
            r_cur    <= r_cur + AW'(1);
            if (r_addr != last) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // segment differences, then the signed product
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_dx  <= r_p - r_prev_x;
            r_den <= rd_x - r_prev_x;
            r_dy  <= $signed({1'b0, rd_y}) - $signed({1'b0, r_prev_y});
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_dx}) * r_dy;
        end
    end

    cti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // status flags
    always_comb begin
        o_sts.n_lt2    = (n_sat < CW'(2));
        o_sts.gt_row   = (r_p > rd_x);
        o_sts.lt_row   = (r_p < rd_x);
        o_sts.eq_row   = (r_p == rd_x);
        o_sts.seg_hit  = (r_prev_x < r_p) && (r_p < rd_x);
        o_sts.first    = (r_cur == '0);
        o_sts.at_last  = (r_cur == last);
        o_sts.div_done = div_done;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            unique case (i_cmd.sel)
                cti_pkg::SEL_MATCH: begin
                    r_out.corrected_mw   <= rd_y;
                    r_out.passed_through <= 1'b0;
                end
                cti_pkg::SEL_INTERP: begin
                    r_out.corrected_mw   <= r_prod[33] ? (r_prev_y - quo) : (r_prev_y + quo);
                    r_out.passed_through <= 1'b0;
                end
                default: begin
                    r_out.corrected_mw   <= r_p;
                    r_out.passed_through <= 1'b1;
                end
            endcase
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

/* sv/cti_ctrl.sv */
// ----------------------------------------------------------------------------
// cti_ctrl
// Item sequencer: row writes, and for lookups a range check, row scan, then
// multiply and divide for an interpolated result.
// ----------------------------------------------------------------------------
module cti_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_cmd_bit,
    input  cti_pkg::t_ctl_sts i_sts,
    output cti_pkg::t_ctl_cmd o_cmd,
    output logic              busy
);

    cti_pkg::t_state r_state;
    cti_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cti_pkg::S_IDLE: begin
                if (start && (i_cmd_bit == cti_pkg::CMD_LOOKUP)) begin
                    n_state = cti_pkg::S_RD_LAST;
                end
            end
            cti_pkg::S_RD_LAST: begin
                n_state = i_sts.n_lt2 ? cti_pkg::S_IDLE : cti_pkg::S_CHK_LAST;
            end
            cti_pkg::S_CHK_LAST: begin
                n_state = i_sts.gt_row ? cti_pkg::S_IDLE : cti_pkg::S_SCAN;
            end
            cti_pkg::S_SCAN: begin
                priority if (i_sts.first && i_sts.lt_row) begin
                    n_state = cti_pkg::S_IDLE;
                end else if (!i_sts.first && i_sts.seg_hit) begin
                    n_state = cti_pkg::S_MUL;
                end else if (i_sts.eq_row || i_sts.at_last) begin
                    n_state = cti_pkg::S_IDLE;
                end else begin
                    n_state = cti_pkg::S_SCAN;
                end
            end
            cti_pkg::S_MUL: begin
                n_state = cti_pkg::S_DIV_GO;
            end
            cti_pkg::S_DIV_GO: begin
                n_state = cti_pkg::S_DIV;
            end
            cti_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = cti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cti_pkg::S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd     = '0;
        o_cmd.sel = cti_pkg::SEL_PASS;
        unique case (r_state)
            cti_pkg::S_IDLE: begin
                if (start) begin
                    if (i_cmd_bit == cti_pkg::CMD_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            cti_pkg::S_RD_LAST: begin
                if (i_sts.n_lt2) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.addr_zero = 1'b1;
                end
            end
            cti_pkg::S_CHK_LAST: begin
                if (i_sts.gt_row) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.scan_init = 1'b1;
                end
            end
            cti_pkg::S_SCAN: begin
                priority if (i_sts.first && i_sts.lt_row) begin
                    o_cmd.emit = 1'b1;
                end else if (!i_sts.first && i_sts.seg_hit) begin
                    o_cmd.seg = 1'b1;
                end else if (i_sts.eq_row) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = cti_pkg::SEL_MATCH;
                end else if (i_sts.at_last) begin
                    o_cmd.emit = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            cti_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            cti_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
            end
            cti_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = cti_pkg::SEL_INTERP;
                end
            end
            default: begin
                o_cmd.sel = cti_pkg::SEL_PASS;
            end
        endcase
    end

    assign busy = (r_state != cti_pkg::S_IDLE);

endmodule
